// ===== rtl/text_console_cell_engine_assert.svh =====
// assertion macros used by the console engine checker
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TCCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcce assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define TCCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcce assertion failed");

`endif

// ===== rtl/tcce_pkg.sv =====
// shared types, constants and helpers of the text console cell engine
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int MAX_COLS    = 80;
  localparam int MAX_ROWS    = 25;
  localparam int CELLS       = MAX_COLS * MAX_ROWS;
  localparam int IDX_W       = $clog2(CELLS);
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_TEXT_COLOR  = 2'd0;
  localparam logic [1:0] REG_BLANK_COLOR = 2'd1;
  localparam logic [1:0] REG_COLUMNS     = 2'd2;
  localparam logic [1:0] REG_ROWS        = 2'd3;

  // control characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TEXT,
    OP_BS,
    OP_NL,
    OP_CR,
    OP_WRITE,
    OP_READ,
    OP_CURSOR,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [7:0]       color;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] cols;
  } geom_t;

  typedef struct packed {
    logic [7:0] text_color;
    logic [7:0] blank_color;
    geom_t      geom;
  } cfg_t;

  // result word, read_char in the lowest bits
  typedef struct packed {
    logic [1:0]       pad;
    logic             scrolled;
    logic             status;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       read_color;
    logic [7:0]       read_char;
  } result_t;

  function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] raw);
    logic [COL_W-1:0] v;
    v = raw;
    if (raw == '0) v = COL_W'(1);
    else if (raw > COL_W'(MAX_COLS)) v = COL_W'(MAX_COLS);
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] eff_rows(input logic [ROW_W-1:0] raw);
    logic [ROW_W-1:0] v;
    v = raw;
    if (raw == '0) v = ROW_W'(1);
    else if (raw > ROW_W'(MAX_ROWS)) v = ROW_W'(MAX_ROWS);
    return v;
  endfunction

endpackage

// ===== rtl/text_console_cell_engine.sv =====
// top level of the text console cell engine
`timescale 1ns / 1ps

// text console over a 2000-cell character/colour store with a cursor. each
// request on the s_ side carries one command and gives exactly one result on
// the m_ side. after reset a clearing pass writes every cell to a space with
// colour zero, one cell a cycle; s_tready stays low until it ends, while
// configuration writes are taken as ever. an ordinary command goes through
// the back end in steps (address/cursor step, store access, result), one
// command at a time. the cell store has one read and one write port: clear
// writes one cell a cycle over columns*rows cells; a scroll copies one cell a
// cycle and then blanks the bottom row. a two-request queue sits between
// intake and execution, so requests keep being taken while a result waits,
// until the queue is full.
module text_console_cell_engine (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0] char_code[10:3] color_code[18:11] row_index[23:19]
  // col_index[30:24], bit 31 zero
  input  logic [31:0] s_tdata,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_char[7:0] read_color[15:8] cursor_row[20:16] cursor_col[27:21]
  // status[28] scrolled[29], bits 31:30 zero
  output logic [31:0] m_tdata
);
  import tcce_pkg::*;

  // configuration registers, kept raw; clamping to the screen limits
  // happens where they are used
  logic [7:0]       text_color;
  logic [7:0]       blank_color;
  logic [COL_W-1:0] columns_in_use;
  logic [ROW_W-1:0] rows_in_use;

  cfg_t    cfg;
  item_t   push_item;
  item_t   pop_item;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  logic    busy;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color     <= 8'd7;
      blank_color    <= 8'd7;
      columns_in_use <= COL_W'(MAX_COLS);
      rows_in_use    <= ROW_W'(MAX_ROWS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_COLOR:  text_color     <= cfg_data;
        REG_BLANK_COLOR: blank_color    <= cfg_data;
        REG_COLUMNS:     columns_in_use <= cfg_data[COL_W-1:0];
        REG_ROWS:        rows_in_use    <= cfg_data[ROW_W-1:0];
        default:         ;
      endcase
    end
  end

  assign cfg.text_color  = text_color;
  assign cfg.blank_color = blank_color;
  assign cfg.geom.cols   = columns_in_use;
  assign cfg.geom.rows   = rows_in_use;

  // intake: decode and bounds check against the current screen
  tcce_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .busy     (busy),
    .geom     (cfg.geom),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // decouples intake from the store sequencer
  tcce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // cursor, store sweeps and the result register
  tcce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = res;

endmodule

// ===== rtl/tcce_front.sv =====
// front end: request intake and command classification
`timescale 1ns / 1ps

module tcce_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,
  input  logic            busy,
  input  tcce_pkg::geom_t geom,
  input  logic            q_full,
  output logic            q_push,
  output tcce_pkg::item_t q_item
);
  import tcce_pkg::*;

  logic [2:0]       cmd;
  logic [7:0]       ch;
  logic [7:0]       color;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             on_screen;

  assign cmd   = s_tdata[2:0];
  assign ch    = s_tdata[10:3];
  assign color = s_tdata[18:11];
  assign row   = s_tdata[23:19];
  assign col   = s_tdata[30:24];

  assign on_screen = (row < eff_rows(geom.rows)) && (col < eff_cols(geom.cols));

  always_comb begin
    q_item.ch    = ch;
    q_item.color = color;
    q_item.row   = row;
    q_item.col   = col;
    case (cmd)
      CMD_PUT: begin
        case (ch)
          CH_BS:   q_item.op = OP_BS;
          CH_NL:   q_item.op = OP_NL;
          CH_CR:   q_item.op = OP_CR;
          default: q_item.op = OP_TEXT;
        endcase
      end
      CMD_WRITE:  q_item.op = on_screen ? OP_WRITE : OP_REJECT;
      CMD_READ:   q_item.op = on_screen ? OP_READ : OP_REJECT;
      CMD_CURSOR: q_item.op = on_screen ? OP_CURSOR : OP_REJECT;
      CMD_CLEAR:  q_item.op = OP_CLEAR;
      default:    q_item.op = OP_NOP;
    endcase
  end

  assign s_tready = !q_full && !busy;
  assign q_push   = s_tvalid && s_tready;

endmodule

// ===== rtl/tcce_queue.sv =====
// short command queue between front and back end
`timescale 1ns / 1ps

module tcce_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcce_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output tcce_pkg::item_t pop_item,
  output logic            empty
);
  import tcce_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/tcce_back.sv =====
// back end: cursor, cell store sequencer and result register
`timescale 1ns / 1ps

module tcce_back (
  input  logic              clk,
  input  logic              rst,
  input  tcce_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  tcce_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              busy,
  output logic              m_tvalid,
  input  logic              m_tready,
  output tcce_pkg::result_t res
);
  import tcce_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CALC   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t           state;
  item_t            item;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] area;
  logic             scroll;
  logic [IDX_W-1:0] sc_src;
  logic             pend;
  logic [IDX_W-1:0] pend_addr;
  logic [IDX_W-1:0] fill_addr;
  logic [IDX_W-1:0] fill_end;
  logic [7:0]       fill_color;
  logic             init;

  // cell store
  logic [15:0]      mem [CELLS];
  logic [15:0]      rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic [COL_W-1:0] w;
  logic [ROW_W-1:0] h;
  logic [ROW_W-1:0] cr;
  logic [COL_W-1:0] cc;
  logic [ROW_W-1:0] arow;
  logic [COL_W-1:0] acol;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic             scroll_next;
  logic [ROW_W+COL_W-1:0] prod;
  logic [ROW_W+COL_W-1:0] lin;
  logic [ROW_W+COL_W-1:0] area_full;
  logic             out_free;
  logic             sc_issue;

  assign w        = eff_cols(cfg.geom.cols);
  assign h        = eff_rows(cfg.geom.rows);
  assign out_free = !m_tvalid || m_tready;
  assign busy     = init;
  assign q_pop    = !q_empty && ((state == ST_IDLE) || ((state == ST_DONE) && out_free));
  assign sc_issue = (sc_src < area);

  // cursor clamped into the current screen
  assign cr = (cur_row >= h) ? h - 1'b1 : cur_row;
  assign cc = (cur_col >= w) ? w - 1'b1 : cur_col;

  // cursor step and target cell
  always_comb begin
    arow        = cr;
    acol        = cc;
    row_next    = cr;
    col_next    = cc;
    scroll_next = 1'b0;
    case (item.op)
      OP_TEXT: begin
        if (cc == w - 1'b1) begin
          col_next = '0;
          if (cr == h - 1'b1) scroll_next = 1'b1;
          else row_next = cr + 1'b1;
        end else begin
          col_next = cc + 1'b1;
        end
      end
      OP_BS: begin
        col_next = (cc != '0) ? cc - 1'b1 : '0;
        acol     = col_next;
      end
      OP_NL: begin
        col_next = '0;
        if (cr == h - 1'b1) scroll_next = 1'b1;
        else row_next = cr + 1'b1;
      end
      OP_CR:     col_next = '0;
      OP_WRITE, OP_READ: begin
        arow = item.row;
        acol = item.col;
      end
      OP_CURSOR: begin
        row_next = item.row;
        col_next = item.col;
      end
      OP_CLEAR: begin
        row_next = '0;
        col_next = '0;
      end
      default: ;
    endcase
  end

  assign prod      = arow * w;
  assign lin       = prod + (ROW_W + COL_W)'(acol);
  assign area_full = h * w;

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = {cfg.text_color, item.ch};
    mem_re    = 1'b0;
    mem_raddr = addr;
    case (state)
      ST_EXEC: begin
        case (item.op)
          OP_TEXT:  mem_we = 1'b1;
          OP_BS: begin
            mem_we    = 1'b1;
            mem_wdata = {cfg.text_color, CH_SPACE};
          end
          OP_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = {item.color, item.ch};
          end
          OP_READ:  mem_re = 1'b1;
          default:  ;
        endcase
      end
      ST_SCROLL: begin
        mem_re    = sc_issue;
        mem_raddr = sc_src;
        mem_we    = pend;
        mem_waddr = pend_addr;
        mem_wdata = rdata;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr;
        mem_wdata = {fill_color, CH_SPACE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      init       <= 1'b1;
      fill_addr  <= '0;
      fill_end   <= IDX_W'(CELLS - 1);
      fill_color <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      pend       <= 1'b0;
      scroll     <= 1'b0;
      sc_src     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          // keep the cursor on the screen across size writes
          cur_row <= cr;
          cur_col <= cc;
          if (q_pop) begin
            item  <= q_item;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          addr    <= lin[IDX_W-1:0];
          area    <= area_full[IDX_W-1:0];
          cur_row <= row_next;
          cur_col <= col_next;
          scroll  <= scroll_next;
          state   <= ST_EXEC;
        end
        ST_EXEC: begin
          if (scroll) begin
            sc_src <= IDX_W'(w);
            pend   <= 1'b0;
            state  <= ST_SCROLL;
          end else if (item.op == OP_CLEAR) begin
            fill_addr  <= '0;
            fill_end   <= area - IDX_W'(1);
            fill_color <= cfg.blank_color;
            state      <= ST_FILL;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SCROLL: begin
          if (sc_issue) begin
            sc_src    <= sc_src + 1'b1;
            pend      <= 1'b1;
            pend_addr <= sc_src - IDX_W'(w);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              fill_addr  <= area - IDX_W'(w);
              fill_end   <= area - IDX_W'(1);
              fill_color <= cfg.blank_color;
              state      <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (fill_addr == fill_end) begin
            if (init) begin
              init  <= 1'b0;
              state <= ST_IDLE;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            fill_addr <= fill_addr + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res.pad            <= '0;
            res.scrolled       <= scroll;
            res.status         <= (item.op == OP_REJECT);
            res.cursor_col     <= cur_col;
            res.cursor_row     <= cur_row;
            res.read_color     <= (item.op == OP_READ) ? rdata[15:8] : '0;
            res.read_char      <= (item.op == OP_READ) ? rdata[7:0] : '0;
            if (q_pop) begin
              item  <= q_item;
              state <= ST_CALC;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tcce_checker.sv =====
// port-level checks of the text console cell engine, bound to the top level
`timescale 1ns / 1ps
`include "text_console_cell_engine_assert.svh"

module tcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import tcce_pkg::*;

  logic req_seen;

  assign req_seen = s_tvalid && s_tready && (s_tdata[31] == 1'b0);

  // a stalled result holds
  `TCCE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // a rejected position never scrolls
  `TCCE_ASSERT_IMP(a_status_scroll, m_tvalid, !(m_tdata[28] && m_tdata[29]))

  // a reported cursor always lies on the largest screen
  `TCCE_ASSERT_IMP(a_cursor_range, m_tvalid || req_seen, !m_tvalid || ((m_tdata[27:21] < COL_W'(MAX_COLS)) && (m_tdata[20:16] < ROW_W'(MAX_ROWS))))

  // a rejected command reads nothing back
  `TCCE_ASSERT_IMP(a_reject_no_data, m_tvalid && m_tdata[28], m_tdata[15:0] == 16'd0)

endmodule

bind text_console_cell_engine tcce_checker u_tcce_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
